// ===== sv/onset_tempo_moving_average_macros.svh =====
// Assertion macros for the onset tempo moving-average block.
// Included by the top level; no other dependencies.
`ifndef ONSET_TEMPO_MOVING_AVERAGE_MACROS_SVH
`define ONSET_TEMPO_MOVING_AVERAGE_MACROS_SVH

`ifndef SYNTHESIS
`define OTMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define OTMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define OTMA_ASSERT_IMP(lbl, ante, cons, msg)
`define OTMA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/otma_pkg.sv =====
// Shared types and constants for the onset tempo moving-average block.
// No dependencies.
package otma_pkg;

  localparam int TIME_W  = 24;
  localparam int TEMPO_W = 10;
  localparam int Q_W     = 24;
  localparam int FRAC_W  = 8;
  localparam int PROD_W  = TIME_W + TEMPO_W;
  localparam int DVD_W   = PROD_W + FRAC_W;
  localparam int HI_W    = DVD_W - Q_W;
  localparam int STEP_W  = $clog2(Q_W);
  localparam int CNT_W   = 5;
  localparam int IN_W    = 64;
  localparam int OUT_W   = 48;

  localparam logic [CNT_W-1:0] COUNT_MAX = 5'd31;
  localparam logic [Q_W-1:0]   Q_MAX     = 24'h7FFFFF;
  localparam logic [Q_W-1:0]   Q_MIN     = 24'h800000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_LT_GO,
    S_LT_WAIT,
    S_LT_FIX,
    S_LOAD,
    S_PUSH,
    S_AVG_GO,
    S_AVG_WAIT,
    S_AVG_FIX,
    S_EMIT
  } otma_state_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

endpackage

// ===== sv/otma_div.sv =====
// Shared restoring divider: one quotient bit per cycle, Q_W steps.
// Flags a quotient of Q_W bits or more as overflow. Depends on otma_pkg.
module otma_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [otma_pkg::DVD_W-1:0] dividend,
  input  logic [otma_pkg::Q_W-1:0]   divisor,
  output otma_pkg::div_stat_t        stat,
  output logic [otma_pkg::Q_W-1:0]   quotient
);
  import otma_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic              ovf_r;
  logic [STEP_W-1:0] step_r;
  logic [Q_W-1:0]    rem_r;
  logic [Q_W-1:0]    quo_r;
  logic [Q_W-1:0]    den_r;
  logic [Q_W:0]      trial;
  logic [Q_W:0]      diff;
  logic              ge;

  always_comb begin
    trial = {rem_r, quo_r[Q_W-1]};
    diff  = trial - {1'b0, den_r};
    ge    = trial >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(Q_W - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= Q_W'(dividend[DVD_W-1:Q_W]);
      quo_r <= dividend[Q_W-1:0];
      den_r <= divisor;
      ovf_r <= Q_W'(dividend[DVD_W-1:Q_W]) >= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
      quo_r <= {quo_r[Q_W-2:0], ge};
    end
  end

  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;
  assign quotient  = quo_r;

endmodule

// ===== sv/onset_tempo_moving_average.sv =====
// Onset tempo moving average: local tempo per matched onset plus windowed mean.
// Depends on otma_pkg, otma_div and onset_tempo_moving_average_macros.svh.
//
//   channel | dir | tdata (low bit up)                          | side
//   in_     | in  | score_time_ms 24, played_time_ms 24,        | -
//           |     | score_tempo_bpm 10, zero pad 6              |
//   out_    | out | local_tempo 24, average_tempo 24            | tuser zero_interval,
//           |     |                                             | tlast last_of_run
//
// One input transfer a time; in_tready is high only while the sequencer is idle.
// A dropped or first row starts no divider pass, the second row one pass and every
// later row two, each a 24-step pass of the shared divider.
// Output register decouples out_tready; a stall holds the sequencer only in S_EMIT.
// Synchronous active-low reset clears the sequencer, count, window pointer and sum.
`include "onset_tempo_moving_average_macros.svh"

module onset_tempo_moving_average #(
  parameter int WINDOW = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [otma_pkg::IN_W-1:0]  in_tdata,   // score_time_ms, played_time_ms, score_tempo_bpm
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [otma_pkg::OUT_W-1:0] out_tdata,  // local_tempo, average_tempo
  output logic                       out_tuser,  // zero_interval
  output logic                       out_tlast
);
  import otma_pkg::*;

  localparam int PTR_W  = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SUM_W  = Q_W + $clog2(WINDOW);
  localparam logic [CNT_W-1:0]  WIN_C    = CNT_W'(WINDOW);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW);

  otma_state_t state_r, state_nxt;

  logic [TIME_W-1:0]  st_in, pt_in;
  logic [TEMPO_W-1:0] tp_in;
  logic               accept, take_row;

  logic [CNT_W-1:0]   count_r;
  logic [TIME_W-1:0]  prev_st_r, prev_pt_r;
  logic [TEMPO_W-1:0] first_tp_r, tp_r;
  logic [TIME_W-1:0]  ds_r;
  logic signed [TIME_W:0] dp_r;
  logic [TIME_W-1:0]  dp_mag;
  logic               pair_r, second_r, full_r;
  logic [FILL_W-1:0]  fill_r;
  logic [PROD_W-1:0]  prod_r;
  logic [Q_W-1:0]     dabs_r;
  logic               neg_r, zero_r;
  logic [Q_W-1:0]     lt_r, avg_r;
  logic signed [Q_W-1:0] old_r;
  logic signed [Q_W-1:0] hist [WINDOW];
  logic signed [SUM_W-1:0] sum_r;
  logic [SUM_W-1:0]   sum_mag;
  logic [PTR_W-1:0]   ptr_r;

  logic               div_start;
  logic [DVD_W-1:0]   div_dividend;
  logic [Q_W-1:0]     div_divisor;
  div_stat_t          dstat;
  logic [Q_W-1:0]     quo;

  logic               emit_ok, out_load;
  logic               out_tvalid_r, out_tuser_r, out_tlast_r;
  logic [OUT_W-1:0]   out_tdata_r;

  assign st_in    = in_tdata[TIME_W-1:0];
  assign pt_in    = in_tdata[2*TIME_W-1:TIME_W];
  assign tp_in    = in_tdata[2*TIME_W+TEMPO_W-1:2*TIME_W];
  assign accept   = in_tvalid && in_tready;
  assign take_row = accept && (count_r != '0) && (st_in > prev_st_r);
  assign emit_ok  = !out_tvalid_r || out_tready;
  assign dp_mag   = dp_r[TIME_W] ? TIME_W'(-dp_r) : TIME_W'(dp_r);
  assign sum_mag  = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);

  otma_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .stat     (dstat),
    .quotient (quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (take_row) state_nxt = S_MUL;
      S_MUL:      state_nxt = S_LT_GO;
      S_LT_GO:    state_nxt = S_LT_WAIT;
      S_LT_WAIT:  if (dstat.done) state_nxt = S_LT_FIX;
      S_LT_FIX:   state_nxt = S_LOAD;
      S_LOAD:     state_nxt = S_PUSH;
      S_PUSH:     state_nxt = pair_r ? S_EMIT : S_AVG_GO;
      S_AVG_GO:   state_nxt = S_AVG_WAIT;
      S_AVG_WAIT: if (dstat.done) state_nxt = S_AVG_FIX;
      S_AVG_FIX:  state_nxt = S_EMIT;
      S_EMIT: begin
        if (emit_ok) state_nxt = (pair_r && !second_r) ? S_LOAD : S_IDLE;
      end
      default:    state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready    = (state_r == S_IDLE);
    div_start    = 1'b0;
    div_dividend = {prod_r, FRAC_W'(0)};
    div_divisor  = dabs_r;
    out_load     = 1'b0;
    case (state_r)
      S_LT_GO:  div_start = 1'b1;
      S_AVG_GO: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'(sum_mag);
        div_divisor  = Q_W'(fill_r);
      end
      S_EMIT:   out_load = emit_ok;
      default:  div_start = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      first_tp_r <= '0;
      ptr_r      <= '0;
      sum_r      <= '0;
      second_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && count_r == '0) begin
        first_tp_r <= tp_in;
        count_r    <= CNT_W'(1);
      end else if (take_row) begin
        second_r <= 1'b0;
        if (count_r != COUNT_MAX) count_r <= count_r + 1'b1;
      end
      if (state_r == S_PUSH) begin
        sum_r <= sum_r + SUM_W'(signed'(lt_r)) - (full_r ? SUM_W'(old_r) : SUM_W'(0));
        ptr_r <= (ptr_r == PTR_LAST) ? '0 : ptr_r + 1'b1;
      end
      if (out_load && pair_r && !second_r) second_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && count_r == '0) begin
      prev_st_r <= st_in;
      prev_pt_r <= pt_in;
    end else if (take_row) begin
      ds_r      <= st_in - prev_st_r;
      dp_r      <= $signed({1'b0, pt_in}) - $signed({1'b0, prev_pt_r});
      tp_r      <= (count_r == CNT_W'(1)) ? first_tp_r : tp_in;
      pair_r    <= (count_r == CNT_W'(1));
      full_r    <= (count_r >= WIN_C);
      fill_r    <= (count_r >= WIN_C) ? FILL_MAX : FILL_W'(count_r + 1'b1);
      prev_st_r <= st_in;
      prev_pt_r <= pt_in;
    end
    if (state_r == S_MUL) begin
      prod_r <= PROD_W'(ds_r) * PROD_W'(tp_r);
      dabs_r <= dp_mag;
      neg_r  <= dp_r[TIME_W];
      zero_r <= (dp_r == '0);
    end
    if (state_r == S_LT_FIX) begin
      if (zero_r) begin
        lt_r <= Q_MAX;
      end else if (!neg_r) begin
        lt_r <= (dstat.ovf || quo[Q_W-1]) ? Q_MAX : quo;
      end else begin
        lt_r <= (dstat.ovf || (quo[Q_W-1] && quo[Q_W-2:0] != '0)) ? Q_MIN : Q_W'(-quo);
      end
    end
    if (state_r == S_LOAD) old_r <= hist[ptr_r];
    if (state_r == S_PUSH) hist[ptr_r] <= signed'(lt_r);
    if (state_r == S_AVG_FIX) avg_r <= sum_r[SUM_W-1] ? Q_W'(-quo) : quo;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {(pair_r ? lt_r : avg_r), lt_r};
      out_tuser_r <= zero_r;
      out_tlast_r <= !(pair_r && !second_r);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign out_tlast  = out_tlast_r;

  `OTMA_ASSERT_IMP(a_div_done_in_wait, dstat.done, (state_r == S_LT_WAIT) || (state_r == S_AVG_WAIT), "divider done outside a wait state")
  `OTMA_ASSERT_IMP(a_zero_saturates, out_tvalid && out_tuser, out_tdata[Q_W-1:0] == Q_MAX, "zero interval without saturated tempo")
  `OTMA_ASSERT_NXT(a_pair_continues, out_load && pair_r && !second_r, state_r == S_LOAD, "first result of a pair not followed by second push")
  `OTMA_ASSERT_IMP(a_ready_only_idle, in_tready, !div_start && !out_load, "input ready while sequencer busy")

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for onset_tempo_moving_average: streams matched onset rows,
// predicts local tempo and windowed mean per row that yields a result, and checks every result transfer.
// Depends on otma_pkg and the onset_tempo_moving_average RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import otma_pkg::*;

  localparam int WIN = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam longint SAT_HI = 64'sd8388607;
  localparam longint SAT_LO = -64'sd8388608;

  typedef struct {
    logic [23:0] score;
    logic [23:0] played;
    logic [9:0]  bpm;
  } onset_row_t;

  typedef struct {
    logic [23:0] local_q8;
    logic [23:0] avg_q8;
    logic        zero_dp;
    logic        last;
  } tempo_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic out_tuser;
  logic out_tlast;

  onset_row_t    onset_rows[$];
  tempo_result_t tempo_expect[$];
  onset_row_t    cur_row;
  bit            in_xfer = 1'b0;
  bit            idle_on = 1'b1;
  int            in_gap = 0;
  int            out_gap = 0;
  int            calm_left = 0;
  int            cycles = 0;
  int            errors = 0;

  // predictor state
  int          acc_cnt = 0;
  logic [23:0] prev_score = '0;
  logic [23:0] prev_played = '0;
  logic [9:0]  first_bpm = '0;
  longint      hist[WIN];
  int          hist_ptr = 0;
  longint      hist_sum = 0;

  onset_tempo_moving_average #(.WINDOW(WIN)) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("mismatch @%0d: %s got %0d want %0d", cycles, what, got, want);
    errors++;
  endtask

  task automatic queue_row(logic [23:0] score, logic [23:0] played, logic [9:0] bpm);
    onset_row_t r;
    r.score = score;
    r.played = played;
    r.bpm = bpm;
    onset_rows.push_back(r);
  endtask

  function automatic longint tempo_ratio_q8(logic [23:0] ds, longint dp, logic [9:0] bpm,
                                            output logic zero_dp);
    longint num;
    longint q;
    zero_dp = (dp == 0);
    if (zero_dp) return SAT_HI;
    num = longint'(ds) * longint'(bpm) * 256;
    q = num / dp;
    if (q > SAT_HI) q = SAT_HI;
    if (q < SAT_LO) q = SAT_LO;
    return q;
  endfunction

  task automatic push_window(longint lt, int fill_before, logic zero_dp, logic last);
    tempo_result_t e;
    int fill;
    longint avg;
    if (fill_before >= WIN) begin
      hist_sum -= hist[hist_ptr];
      fill = WIN;
    end else begin
      fill = fill_before + 1;
    end
    hist[hist_ptr] = lt;
    hist_sum += lt;
    hist_ptr = (hist_ptr + 1) % WIN;
    avg = hist_sum / fill;
    e.local_q8 = lt[23:0];
    e.avg_q8 = avg[23:0];
    e.zero_dp = zero_dp;
    e.last = last;
    tempo_expect.push_back(e);
  endtask

  task automatic track_onset(onset_row_t r);
    logic [23:0] ds;
    longint dp;
    longint lt;
    logic z;
    if (acc_cnt == 0) begin
      prev_score = r.score;
      prev_played = r.played;
      first_bpm = r.bpm;
      acc_cnt = 1;
      return;
    end
    if (r.score <= prev_score) return;
    ds = r.score - prev_score;
    dp = longint'(r.played) - longint'(prev_played);
    if (acc_cnt == 1) begin
      lt = tempo_ratio_q8(ds, dp, first_bpm, z);
      push_window(lt, 0, z, 1'b0);
      push_window(lt, 1, z, 1'b1);
    end else begin
      lt = tempo_ratio_q8(ds, dp, r.bpm, z);
      push_window(lt, (acc_cnt < WIN) ? acc_cnt : WIN, z, 1'b1);
    end
    prev_score = r.score;
    prev_played = r.played;
    if (acc_cnt < 31) acc_cnt++;
  endtask

  // cycle count, timeout, and random quiet stretches
  always @(posedge clk) begin
    cycles++;
    if (calm_left > 0) calm_left--;
    else if ($urandom_range(0, 299) == 0) calm_left = $urandom_range(100, 400);
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      track_onset(cur_row);
      in_xfer = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && !(in_tvalid && !in_xfer)) begin
      in_xfer = 1'b0;
      idle_on = onset_rows.size() > 80;
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (onset_rows.size() > 0) begin
        cur_row = onset_rows.pop_front();
        in_tdata <= {6'b0, cur_row.bpm, cur_row.played, cur_row.score};
        in_tvalid <= 1'b1;
        if (idle_on && calm_left == 0 && $urandom_range(0, 3) == 0)
          in_gap = $urandom_range(1, 11);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (idle_on && calm_left == 0 && $urandom_range(0, 5) == 0)
          out_gap = $urandom_range(1, 11);
      end
    end
  end

  always @(posedge clk) begin : result_check
    tempo_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (tempo_expect.size() == 0) begin
        flag_mismatch("unexpected transfer, local_tempo", longint'(out_tdata[23:0]), 0);
      end else begin
        e = tempo_expect.pop_front();
        if (out_tdata[23:0] !== e.local_q8)
          flag_mismatch("local_tempo", longint'($signed(out_tdata[23:0])),
                        longint'($signed(e.local_q8)));
        if (out_tdata[47:24] !== e.avg_q8)
          flag_mismatch("average_tempo", longint'($signed(out_tdata[47:24])),
                        longint'($signed(e.avg_q8)));
        if (out_tuser !== e.zero_dp)
          flag_mismatch("zero_interval", longint'(out_tuser), longint'(e.zero_dp));
        if (out_tlast !== e.last)
          flag_mismatch("last_of_run", longint'(out_tlast), longint'(e.last));
      end
    end
  end

  initial begin : stimulus
    int gen_score;
    int gen_played;
    int delta;
    int pdelta;
    int pick;

    // directed rows
    queue_row(24'd0, 24'd0, 10'd0);           // first row, no result
    queue_row(24'd0, 24'd5, 10'd100);         // equal score time, dropped
    queue_row(24'd1000, 24'd500, 10'd1023);   // second row uses zero first tempo
    queue_row(24'd500, 24'd900, 10'd7);       // earlier score time, dropped
    queue_row(24'd2000, 24'd1000, 10'd120);
    queue_row(24'd3000, 24'd1000, 10'd200);   // zero performed interval
    queue_row(24'd4000, 24'd200, 10'd60);     // performed time going backward
    queue_row(24'd4001, 24'd201, 10'd1023);
    queue_row(24'h400000, 24'd202, 10'd1023); // saturates high
    queue_row(24'h500000, 24'd201, 10'd1023); // saturates low
    queue_row(24'h500001, 24'hFFFFFF, 10'd0);
    queue_row(24'h500002, 24'd0, 10'd1023);
    queue_row(24'h500003, 24'd0, 10'd512);
    queue_row(24'h500004, 24'd0, 10'd512);    // zero interval with full window
    queue_row(24'h510000, 24'd30000, 10'd90);
    queue_row(24'h510000, 24'd1, 10'd90);     // dropped
    queue_row(24'h520000, 24'd95000, 10'd240);
    queue_row(24'h520100, 24'd94000, 10'd333);
    gen_score = 'h800000;
    gen_played = 94000;

    for (int k = 0; k < 630; k++) begin
      if ($urandom_range(0, 99) < 15) begin
        queue_row(24'($urandom_range(0, gen_score)), 24'($urandom),
                  10'($urandom_range(0, 1023)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 20) delta = $urandom_range(1, 255);
        else if (pick < 99) delta = $urandom_range(1, 16000);
        else delta = $urandom_range(100000, 400000);
        if (gen_score > 'hFFFFFE - delta) delta = 0;
        gen_score += delta;
        pick = $urandom_range(0, 99);
        if (pick < 10) pdelta = 0;
        else if (pick < 25) pdelta = -$urandom_range(1, 20000);
        else if (pick < 85) pdelta = delta * $urandom_range(50, 200) / 100 + $urandom_range(0, 3);
        else if (pick < 95) pdelta = $urandom_range(1, 100000);
        else pdelta = $urandom;
        gen_played = (gen_played + pdelta) & 'hFFFFFF;
        queue_row(24'(gen_score), 24'(gen_played),
                  ($urandom_range(0, 4) == 0) ? 10'($urandom_range(0, 1023))
                                              : 10'($urandom_range(40, 240)));
      end
    end
    queue_row(24'hFFFFFF, 24'($urandom), 10'($urandom_range(0, 1023)));
    queue_row(24'hFFFFFF, 24'($urandom), 10'($urandom_range(0, 1023)));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    while (onset_rows.size() > 0 || in_tvalid) @(posedge clk);
    while (tempo_expect.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
